// ===== sv/aff_pkg.sv =====
`timescale 1ns / 1ps
package aff_pkg;

  // Coordinate and fixed-point format
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned SAT_BITS    = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  localparam int unsigned IO_W    = 32;
  localparam int unsigned MUL_W   = 2 * IO_W;
  localparam int unsigned PROD_W  = MUL_W - FRAC_BITS;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CORNERS = 4;

  localparam logic signed [IO_W-1:0] COEF_ONE = IO_W'(1) << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAT_BITS+1){1'b0}}, {(SAT_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [KIND_W-1:0] KIND_IDENTITY  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_TRANSLATE = KIND_W'(1);

  typedef enum logic [1:0] {
    OP_POINT         = 2'd0,
    OP_POINT_NO_OFS  = 2'd1,
    OP_BOUNDS        = 2'd2,
    OP_BOUNDS_NO_OFS = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_YX  = 3'd1,
    REG_COEF_XY  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_KIND     = 3'd6
  } cfg_reg_e;

  // Per-word control carried down the pipeline
  typedef struct packed {
    logic pass;
    logic trans;
    logic use_ofs;
    logic bounds;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic                   sat;
    logic signed [IO_W-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp_coord(logic signed [ACC_W-1:0] v);
    clamp_t r;
    r.sat = 1'b0;
    if (v > SAT_HI) begin
      r.sat = 1'b1;
      r.val = IO_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r.sat = 1'b1;
      r.val = IO_W'(SAT_LO);
    end else begin
      r.val = IO_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/affine_point_and_bounds_transform.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// input    | start / busy       | operation_i, x_or_left_i, y_or_top_i,
//          |                    | rect_right_i, rect_bottom_i, last_in_i
// result   | done_o (strobe)    | out_x_or_left_o, out_y_or_top_o, out_right_o,
//          |                    | out_bottom_o, out_last_o, saturated_o
// config   | cfg_we_i           | cfg_index_i, cfg_wdata_i
//
// One word accepted every cycle; busy is always low.
// The result strobe follows these registered stages in order:
// input register, multiplier stage (eight 32x32 products), corner add/offset/clamp
// stage, min/max output stage.
// Reset clears the stage valid bits and loads the identity matrix.
// The receiver cannot stall, so the pipeline never holds.
module affine_point_and_bounds_transform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          operation_i,
  input  logic signed [aff_pkg::IO_W-1:0]     x_or_left_i,
  input  logic signed [aff_pkg::IO_W-1:0]     y_or_top_i,
  input  logic signed [aff_pkg::IO_W-1:0]     rect_right_i,
  input  logic signed [aff_pkg::IO_W-1:0]     rect_bottom_i,
  input  logic                                last_in_i,
  input  logic                                cfg_we_i,
  input  logic [aff_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [aff_pkg::IO_W-1:0]            cfg_wdata_i,
  output logic                                done_o,
  output logic signed [aff_pkg::IO_W-1:0]     out_x_or_left_o,
  output logic signed [aff_pkg::IO_W-1:0]     out_y_or_top_o,
  output logic signed [aff_pkg::IO_W-1:0]     out_right_o,
  output logic signed [aff_pkg::IO_W-1:0]     out_bottom_o,
  output logic                                out_last_o,
  output logic                                saturated_o
);
  import aff_pkg::*;

  // Configuration registers
  logic signed [IO_W-1:0] coef_xx_q, coef_yx_q, coef_xy_q, coef_yy_q;
  logic signed [IO_W-1:0] offset_x_q, offset_y_q;
  logic [KIND_W-1:0]      kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= COEF_ONE;
      coef_yx_q  <= '0;
      coef_xy_q  <= '0;
      coef_yy_q  <= COEF_ONE;
      offset_x_q <= '0;
      offset_y_q <= '0;
      kind_q     <= KIND_IDENTITY;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COEF_XX:  coef_xx_q  <= cfg_wdata_i;
        REG_COEF_YX:  coef_yx_q  <= cfg_wdata_i;
        REG_COEF_XY:  coef_xy_q  <= cfg_wdata_i;
        REG_COEF_YY:  coef_yy_q  <= cfg_wdata_i;
        REG_OFFSET_X: offset_x_q <= cfg_wdata_i;
        REG_OFFSET_Y: offset_y_q <= cfg_wdata_i;
        REG_KIND:     kind_q     <= cfg_wdata_i[KIND_W-1:0];
        default:      ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: input register and operation decode
  logic  accept;
  ctrl_t ctrl1_d;
  assign accept = start && !busy;

  always_comb begin
    ctrl1_d      = '0;
    ctrl1_d.last = last_in_i;
    unique case (op_e'(operation_i))
      OP_POINT: begin
        ctrl1_d.use_ofs = 1'b1;
      end
      OP_POINT_NO_OFS: begin
        ctrl1_d.use_ofs = 1'b0;
      end
      OP_BOUNDS: begin
        ctrl1_d.use_ofs = 1'b1;
        ctrl1_d.bounds  = 1'b1;
      end
      OP_BOUNDS_NO_OFS: begin
        ctrl1_d.use_ofs = 1'b0;
        ctrl1_d.bounds  = 1'b1;
      end
      default: ;
    endcase
    if (ctrl1_d.use_ofs) begin
      ctrl1_d.pass  = (kind_q == KIND_IDENTITY);
      ctrl1_d.trans = (kind_q == KIND_TRANSLATE);
    end else begin
      ctrl1_d.pass  = (kind_q <= KIND_TRANSLATE);
    end
  end

  logic                   v1_q, v2_q, v3_q;
  ctrl_t                  ctrl1_q, ctrl2_q, ctrl3_q;
  // index 0: left/top edge, index 1: right/bottom edge
  logic signed [IO_W-1:0] x1_q [2];
  logic signed [IO_W-1:0] y1_q [2];
  logic signed [IO_W-1:0] x2_q [2];
  logic signed [IO_W-1:0] y2_q [2];
  logic signed [IO_W-1:0] x3_q [2];
  logic signed [IO_W-1:0] y3_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl1_q <= ctrl1_d;
      x1_q[0] <= x_or_left_i;
      x1_q[1] <= rect_right_i;
      y1_q[0] <= y_or_top_i;
      y1_q[1] <= rect_bottom_i;
    end
  end

  // Stage 2: products, floored by an arithmetic shift
  logic signed [PROD_W-1:0] fxx_q [2];
  logic signed [PROD_W-1:0] fxy_q [2];
  logic signed [PROD_W-1:0] fyx_q [2];
  logic signed [PROD_W-1:0] fyy_q [2];
  logic signed [MUL_W-1:0]  pxx [2];
  logic signed [MUL_W-1:0]  pxy [2];
  logic signed [MUL_W-1:0]  pyx [2];
  logic signed [MUL_W-1:0]  pyy [2];

  for (genvar e = 0; e < 2; e++) begin : g_mul
    assign pxx[e] = MUL_W'(x1_q[e]) * MUL_W'(coef_xx_q);
    assign pyx[e] = MUL_W'(x1_q[e]) * MUL_W'(coef_yx_q);
    assign pxy[e] = MUL_W'(y1_q[e]) * MUL_W'(coef_xy_q);
    assign pyy[e] = MUL_W'(y1_q[e]) * MUL_W'(coef_yy_q);

    always_ff @(posedge clk_i) begin
      if (v1_q) begin
        fxx_q[e] <= PROD_W'(pxx[e] >>> FRAC_BITS);
        fyx_q[e] <= PROD_W'(pyx[e] >>> FRAC_BITS);
        fxy_q[e] <= PROD_W'(pxy[e] >>> FRAC_BITS);
        fyy_q[e] <= PROD_W'(pyy[e] >>> FRAC_BITS);
        x2_q[e]  <= x1_q[e];
        y2_q[e]  <= y1_q[e];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      ctrl2_q <= ctrl1_q;
    end
  end

  // Stage 3: corner sums, offset, clamp
  logic signed [IO_W-1:0] cx_q [NUM_CORNERS];
  logic signed [IO_W-1:0] cy_q [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] csat;
  logic                   sat3_q;

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    localparam int XI = k % 2;
    localparam int YI = k / 2;
    logic signed [ACC_W-1:0] acc_x, acc_y;
    clamp_t                  clx, cly;

    always_comb begin
      if (ctrl2_q.trans) begin
        acc_x = ACC_W'(x2_q[XI]);
        acc_y = ACC_W'(y2_q[YI]);
      end else begin
        acc_x = ACC_W'(fxx_q[XI]) + ACC_W'(fxy_q[YI]);
        acc_y = ACC_W'(fyx_q[XI]) + ACC_W'(fyy_q[YI]);
      end
      if (ctrl2_q.use_ofs) begin
        acc_x = acc_x + ACC_W'(offset_x_q);
        acc_y = acc_y + ACC_W'(offset_y_q);
      end
      clx = clamp_coord(acc_x);
      cly = clamp_coord(acc_y);
    end

    // only the first corner counts for a point
    assign csat[k] = (clx.sat || cly.sat) && (k == 0 || ctrl2_q.bounds);

    always_ff @(posedge clk_i) begin
      if (v2_q) begin
        cx_q[k] <= clx.val;
        cy_q[k] <= cly.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      ctrl3_q <= ctrl2_q;
      sat3_q  <= !ctrl2_q.pass && (|csat);
      x3_q    <= x2_q;
      y3_q    <= y2_q;
    end
  end

  // Stage 4: bounding box and result register
  logic signed [IO_W-1:0] min_x01, min_x23, max_x01, max_x23;
  logic signed [IO_W-1:0] min_y01, min_y23, max_y01, max_y23;

  assign min_x01 = (cx_q[1] < cx_q[0]) ? cx_q[1] : cx_q[0];
  assign min_x23 = (cx_q[3] < cx_q[2]) ? cx_q[3] : cx_q[2];
  assign max_x01 = (cx_q[1] > cx_q[0]) ? cx_q[1] : cx_q[0];
  assign max_x23 = (cx_q[3] > cx_q[2]) ? cx_q[3] : cx_q[2];
  assign min_y01 = (cy_q[1] < cy_q[0]) ? cy_q[1] : cy_q[0];
  assign min_y23 = (cy_q[3] < cy_q[2]) ? cy_q[3] : cy_q[2];
  assign max_y01 = (cy_q[1] > cy_q[0]) ? cy_q[1] : cy_q[0];
  assign max_y23 = (cy_q[3] > cy_q[2]) ? cy_q[3] : cy_q[2];

  logic signed [IO_W-1:0] rx_d, ry_d, rr_d, rb_d;

  always_comb begin
    if (ctrl3_q.pass) begin
      rx_d = x3_q[0];
      ry_d = y3_q[0];
      rr_d = ctrl3_q.bounds ? x3_q[1] : '0;
      rb_d = ctrl3_q.bounds ? y3_q[1] : '0;
    end else if (!ctrl3_q.bounds) begin
      rx_d = cx_q[0];
      ry_d = cy_q[0];
      rr_d = '0;
      rb_d = '0;
    end else begin
      rx_d = (min_x23 < min_x01) ? min_x23 : min_x01;
      ry_d = (min_y23 < min_y01) ? min_y23 : min_y01;
      rr_d = (max_x23 > max_x01) ? max_x23 : max_x01;
      rb_d = (max_y23 > max_y01) ? max_y23 : max_y01;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      out_x_or_left_o <= rx_d;
      out_y_or_top_o  <= ry_d;
      out_right_o     <= rr_d;
      out_bottom_o    <= rb_d;
      out_last_o      <= ctrl3_q.last;
      saturated_o     <= sat3_q;
    end
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("accepted word produced no result");

  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v1_q, 3))
    else $error("result without an accepted word");

  a_pass_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ctrl3_q.pass) |=> !saturated_o)
    else $error("pass-through word flagged as saturated");

  a_point_zero_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !ctrl3_q.bounds) |=> (out_right_o == '0 && out_bottom_o == '0))
    else $error("point result with non-zero right or bottom");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ctrl3_q.bounds && !ctrl3_q.pass) |=>
      (out_x_or_left_o <= out_right_o && out_y_or_top_o <= out_bottom_o))
    else $error("bounding box edges out of order");
`endif

endmodule
